### src/trbf_pkg.sv
// ----------------------------------------------------------------------------
// trbf_pkg
// Shared types and constants for the truncated RBF forcing-term block.
// ----------------------------------------------------------------------------
`default_nettype none

package trbf_pkg;

  localparam int MAX_KERNELS_DEF     = 64;
  localparam int EXP_TABLE_DEPTH_DEF = 256;

  // Truncation at TRUNC_MUL * TRUNC_K^2 in Q16.16 after reset.
  localparam int TRUNC_K   = 3;
  localparam int TRUNC_MUL = 2;

  // The exponential table spans t in [0, 16.0): index = t * depth / 2^20.
  localparam int SPAN_SHIFT   = 20;
  localparam int TAYLOR_TERMS = 20;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  localparam logic [1:0] REG_ACTIVE_KERNELS = 2'd0;
  localparam logic [1:0] REG_TRUNC_THRESH   = 2'd1;
  localparam logic [1:0] REG_ZERO_GUARD     = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic [6:0]  ACTIVE_RESET = 7'd64;
  localparam logic [31:0] THRESH_RESET = 32'(TRUNC_MUL * TRUNC_K * TRUNC_K) << 16;
  localparam logic [15:0] GUARD_RESET  = 16'd1;

  typedef struct packed {
    logic [15:0] center;
    logic [31:0] width;
    logic [31:0] slope;
    logic [31:0] offset;
  } kernel_t;

endpackage

`default_nettype wire

### src/truncated_rbf_forcing_term.sv
// ----------------------------------------------------------------------------
// truncated_rbf_forcing_term
// Normalised Gaussian RBF forcing term with truncated activations.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on a valid/ready channel. A write item (opcode 0)
//   stores one kernel in the table and is complete in the cycle of its
//   transfer; it produces no result. An evaluate item (opcode 1) produces
//   one result on the valid/ready output channel.
//   An evaluation steps through the N active kernels in turn. Each kernel
//   needs four passes through the single shared 33x33 multiplier plus the
//   table reads; the quotient is then formed one bit per cycle in the
//   restoring divider, whose dividend is NUM_W = 50 + clog2(MAX_KERNELS)
//   bits wide (56 by default).
//   The input is not ready while an evaluation is in progress. A finished
//   result waits in the output register; the next item is taken while it
//   waits, and a following evaluation holds its own result until the
//   receiver takes the earlier one.
//   Reset restores config register defaults and empties the output register.
//   The kernel table is not cleared and must be written before it is used.
//   The user must write configuration only while idle; the block won't check.
// ----------------------------------------------------------------------------
`default_nettype none

module truncated_rbf_forcing_term #(
  parameter int MAX_KERNELS     = trbf_pkg::MAX_KERNELS_DEF,
  parameter int EXP_TABLE_DEPTH = trbf_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire         [1:0]  cfg_index_i,
  input  wire         [31:0] cfg_wdata_i,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire                opcode_i,
  input  wire         [5:0]  kernel_index_i,
  input  wire         [15:0] center_i,
  input  wire         [31:0] width_factor_i,
  input  wire  signed [31:0] slope_weight_i,
  input  wire  signed [31:0] offset_weight_i,
  input  wire         [15:0] phase_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic signed [31:0] forcing_value_o,
  output logic        [22:0] activation_sum_o
);
  import trbf_pkg::*;

  localparam int AW    = (MAX_KERNELS > 1) ? $clog2(MAX_KERNELS) : 1;
  localparam int CW    = $clog2(MAX_KERNELS + 1);
  localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
  localparam int NUM_W = 50 + $clog2(MAX_KERNELS);
  localparam int PS_W  = 17 + $clog2(MAX_KERNELS);
  localparam int DEN_W = PS_W + 1;
  localparam int ACT_W = (PS_W > 23) ? PS_W : 23;
  localparam int JW    = 33 + $clog2(EXP_TABLE_DEPTH + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_SP   = 4'd2;
  localparam logic [3:0] S_SQ   = 4'd3;
  localparam logic [3:0] S_T    = 4'd4;
  localparam logic [3:0] S_IDX  = 4'd5;
  localparam logic [3:0] S_MAC  = 4'd6;
  localparam logic [3:0] S_ADD  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_WAIT = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  // Configuration registers
  logic [6:0]  active_q;
  logic [31:0] thresh_q;
  logic [15:0] guard_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_RESET;
      thresh_q <= THRESH_RESET;
      guard_q  <= GUARD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ACTIVE_KERNELS: active_q <= cfg_wdata_i[6:0];
        REG_TRUNC_THRESH:   thresh_q <= cfg_wdata_i;
        REG_ZERO_GUARD:     guard_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  logic [3:0] state_q, state_d;
  logic       in_fire;
  logic       eval_start;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign eval_start = in_fire && (opcode_i == OP_EVAL);

  // Kernel table
  logic [31:0] kidx_ext;
  logic        kw_en;
  kernel_t     kw_data;
  kernel_t     krd;
  logic [CW-1:0] kcnt_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] count_sel;

  assign kidx_ext = 32'(kernel_index_i);
  assign kw_en    = in_fire && (opcode_i == OP_WRITE) && (kidx_ext < 32'(MAX_KERNELS));
  assign kw_data  = '{center: center_i, width: width_factor_i,
                      slope: slope_weight_i, offset: offset_weight_i};
  assign count_sel = (32'(active_q) > 32'(MAX_KERNELS)) ? CW'(MAX_KERNELS) : CW'(active_q);

  trbf_kernel_mem #(
    .DEPTH (MAX_KERNELS),
    .AW    (AW)
  ) u_kmem (
    .clk_i   (clk_i),
    .we_i    (kw_en),
    .waddr_i (kidx_ext[AW-1:0]),
    .wdata_i (kw_data),
    .raddr_i (kcnt_q[AW-1:0]),
    .rdata_o (krd)
  );

  // Shared multiplier with a registered product
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_q;
  logic        [16:0] psi;
  logic signed [32:0] a_q;
  logic        [15:0] phase_q;
  logic        [15:0] d_q;

  always_comb begin
    unique case (state_q)
      S_SP: begin
        mul_a = $signed({krd.slope[31], krd.slope});
        mul_b = $signed({17'd0, phase_q});
      end
      S_SQ: begin
        mul_a = $signed({17'd0, d_q});
        mul_b = $signed({17'd0, d_q});
      end
      S_T: begin
        mul_a = $signed({1'b0, krd.width});
        mul_b = $signed({1'b0, mul_q[31:0]});
      end
      S_MAC: begin
        mul_a = a_q;
        mul_b = $signed({16'd0, psi});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // Per-kernel datapath
  logic [15:0]         d_d;
  logic [31:0]         t;
  logic [JW-1:0]       jprod;
  logic [JW-1:0]       jfull;
  logic                ok_q;
  logic [16:0]         rom_data;
  logic [16:0]         psi_q;
  logic signed [NUM_W-1:0] num_q;
  logic [PS_W-1:0]     psum_q;

  assign d_d   = (phase_q >= krd.center) ? phase_q - krd.center : krd.center - phase_q;
  assign t     = mul_q[63:32];
  assign jprod = JW'(t) * JW'(EXP_TABLE_DEPTH);
  assign jfull = (jprod + (JW'(1) << (SPAN_SHIFT - 1))) >> SPAN_SHIFT;
  assign psi   = ok_q ? rom_data : 17'd0;

  trbf_exp_rom #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
    .IDX_W           (IDX_W)
  ) u_exp_rom (
    .clk_i  (clk_i),
    .addr_i (jfull[IDX_W-1:0]),
    .data_o (rom_data)
  );

  always_ff @(posedge clk_i) begin
    if (eval_start) begin
      phase_q <= phase_i;
      count_q <= count_sel;
      num_q   <= '0;
      psum_q  <= '0;
    end
    if (state_q == S_SP) begin
      d_q <= d_d;
    end
    if (state_q == S_SQ) begin
      // floor(slope * phase / 2^16) is an arithmetic shift of the product.
      a_q <= $signed({mul_q[47], mul_q[47:16]})
           + $signed({krd.offset[31], krd.offset});
    end
    if (state_q == S_IDX) begin
      ok_q <= (t <= thresh_q) && (jfull < JW'(EXP_TABLE_DEPTH));
    end
    if (state_q == S_MAC) begin
      psi_q <= psi;
    end
    if (state_q == S_ADD) begin
      num_q  <= num_q + NUM_W'($signed(mul_q[49:0]));
      psum_q <= psum_q + PS_W'(psi_q);
    end
  end

  // Divider
  logic               div_done;
  logic signed [31:0] div_result;

  trbf_divider #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (state_q == S_DIV),
    .num_i    (num_q),
    .den_i    (DEN_W'(psum_q) + DEN_W'(guard_q)),
    .done_o   (div_done),
    .result_o (div_result)
  );

  // Sequencer
  logic out_load;
  logic out_valid_q;

  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (eval_start) begin
          state_d = (count_sel == '0) ? S_DIV : S_LOAD;
        end
      end
      S_LOAD: state_d = S_SP;
      S_SP:   state_d = S_SQ;
      S_SQ:   state_d = S_T;
      S_T:    state_d = S_IDX;
      S_IDX:  state_d = S_MAC;
      S_MAC:  state_d = S_ADD;
      S_ADD:  state_d = (CW'(kcnt_q + 1'b1) == count_q) ? S_DIV : S_LOAD;
      S_DIV:  state_d = S_WAIT;
      S_WAIT: state_d = div_done ? S_OUT : S_WAIT;
      S_OUT:  state_d = out_load ? S_IDLE : S_OUT;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (eval_start) begin
        kcnt_q <= '0;
      end else if (state_q == S_ADD) begin
        kcnt_q <= kcnt_q + 1'b1;
      end
    end
  end

  // Output register
  logic [ACT_W-1:0]   psum_ext;
  logic signed [31:0] fv_q;
  logic [22:0]        act_q;

  assign psum_ext = ACT_W'(psum_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      fv_q  <= div_result;
      act_q <= (psum_ext > ACT_W'(23'h7F_FFFF)) ? 23'h7F_FFFF : psum_ext[22:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign forcing_value_o  = fv_q;
  assign activation_sum_o = act_q;

endmodule

`default_nettype wire

### src/trbf_kernel_mem.sv
// ----------------------------------------------------------------------------
// trbf_kernel_mem
// Kernel parameter table: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module trbf_kernel_mem #(
  parameter int DEPTH = trbf_pkg::MAX_KERNELS_DEF,
  parameter int AW    = 6
) (
  input  wire                    clk_i,
  input  wire                    we_i,
  input  wire  [AW-1:0]          waddr_i,
  input  trbf_pkg::kernel_t      wdata_i,
  input  wire  [AW-1:0]          raddr_i,
  output trbf_pkg::kernel_t      rdata_o
);
  import trbf_pkg::*;

  kernel_t mem [DEPTH];
  kernel_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/trbf_exp_rom.sv
// ----------------------------------------------------------------------------
// trbf_exp_rom
// Constant table of exp(-t) in Q1.16 over t in [0, 16.0), registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module trbf_exp_rom #(
  parameter int EXP_TABLE_DEPTH = trbf_pkg::EXP_TABLE_DEPTH_DEF,
  parameter int IDX_W           = 8
) (
  input  wire              clk_i,
  input  wire  [IDX_W-1:0] addr_i,
  output logic [16:0]      data_o
);
  import trbf_pkg::*;

  // exp(-f) in Q34.30 by a truncated Taylor series, floored at zero.
  function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
    logic [63:0] term;
    logic [63:0] sum;
    term = Q30_ONE;
    sum  = Q30_ONE;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      term = ((term * f) >> 30) / 64'(k);
      if ((k % 2) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic logic [16:0] exp_entry(input int j);
    logic [63:0] num;
    logic [63:0] whole;
    logic [63:0] rem;
    logic [63:0] v;
    logic [63:0] e1;
    num   = 64'(16 * j);
    whole = num / EXP_TABLE_DEPTH;
    rem   = num % EXP_TABLE_DEPTH;
    e1    = exp_neg_frac(Q30_ONE);
    v     = exp_neg_frac((rem << 30) / EXP_TABLE_DEPTH);
    for (int n = 0; n < 16; n++) begin
      if (64'(n) < whole) begin
        v = (v * e1) >> 30;
      end
    end
    return 17'((v + (64'd1 << 13)) >> 14);
  endfunction

  logic [16:0] rom [EXP_TABLE_DEPTH];

  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [16:0] EntryVal = exp_entry(g);
    assign rom[g] = EntryVal;
  end

  logic [16:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= rom[addr_i];
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

### src/trbf_divider.sv
// ----------------------------------------------------------------------------
// trbf_divider
// Restoring signed-by-unsigned divider, one quotient bit per cycle, with
// truncation toward zero and saturation to 32 bits signed; a zero divisor gives zero.
// ----------------------------------------------------------------------------
`default_nettype none

module trbf_divider #(
  parameter int NUM_W = 56,
  parameter int DEN_W = 24
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start_i,
  input  wire  signed [NUM_W-1:0] num_i,
  input  wire         [DEN_W-1:0] den_i,
  output logic                    done_o,
  output logic signed [31:0]      result_o
);
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [NUM_W-1:0] POS_LIM = NUM_W'(64'h0000_0000_7FFF_FFFF);
  localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(64'h0000_0000_8000_0000);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] quo_q;
  logic             neg_q;
  logic             dz_q;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The dividend is shifted out of the top of quo_q while quotient bits
  // enter at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      neg_q <= num_i[NUM_W-1];
      rem_q <= '0;
      den_q <= den_i;
      dz_q  <= (den_i == '0);
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  always_comb begin
    if (dz_q) begin
      result_o = '0;
    end else if (neg_q) begin
      result_o = (quo_q > NEG_LIM) ? 32'sh8000_0000 : -$signed(quo_q[31:0]);
    end else begin
      result_o = (quo_q > POS_LIM) ? 32'sh7FFF_FFFF : $signed(quo_q[31:0]);
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

### test/truncated_rbf_forcing_term_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// truncated_rbf_forcing_term_tb
// Self-checking bench for the truncated RBF forcing-term block. A short table
// of directed rows covers saturation, truncation, empty kernel sets and the
// zero denominator. Randomised phases of kernel writes and evaluations
// follow, each phase under its own register setting. Every evaluation is
// checked against a bit-exact model in the bench or a directed row's value.
// ----------------------------------------------------------------------------
module truncated_rbf_forcing_term_tb;
  import trbf_pkg::*;

  localparam int NKERN        = MAX_KERNELS_DEF;
  localparam int LUT_DEPTH    = EXP_TABLE_DEPTH_DEF;
  localparam int ITEM_TARGET  = 950;
  localparam int SLOWEST_EVAL = 1 + 7 * NKERN + 56 + 3 + 16;
  localparam int NUM_ROWS     = 32;
  localparam int MAX_REPORTS  = 40;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct packed {
    logic [31:0] value;
    logic [22:0] sum;
  } forcing_result_t;

  typedef struct packed {
    row_kind_e       kind;
    logic [1:0]      reg_idx;
    logic [31:0]     reg_val;
    logic            op;
    logic [5:0]      kidx;
    kernel_t         kern;
    logic [15:0]     phase;
    logic            typed;
    forcing_result_t want;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic        [1:0]  cfg_index_i;
  logic        [31:0] cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               opcode_i;
  logic        [5:0]  kernel_index_i;
  logic        [15:0] center_i;
  logic        [31:0] width_factor_i;
  logic signed [31:0] slope_weight_i;
  logic signed [31:0] offset_weight_i;
  logic        [15:0] phase_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] forcing_value_o;
  logic        [22:0] activation_sum_o;

  // Bench copy of the block's state and configuration.
  kernel_t         kernel_bank [NKERN];
  bit              written     [NKERN];
  logic [6:0]      active_q;
  logic [31:0]     thresh_q;
  logic [15:0]     guard_q;
  logic [16:0]     exp_lut     [LUT_DEPTH];

  forcing_result_t pending_results [$];
  forcing_result_t oldest;
  stim_row_t       stim_table [NUM_ROWS];
  int              errors;
  int              items_sent;
  bit              calm;

  truncated_rbf_forcing_term u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .kernel_index_i  (kernel_index_i),
    .center_i        (center_i),
    .width_factor_i  (width_factor_i),
    .slope_weight_i  (slope_weight_i),
    .offset_weight_i (offset_weight_i),
    .phase_i         (phase_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .forcing_value_o (forcing_value_o),
    .activation_sum_o(activation_sum_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // exp(-f) in Q30 for 0 <= f <= 1.0, from a Taylor series truncated per term.
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
    logic [63:0] term;
    logic [63:0] acc;
    term = Q30_ONE;
    acc  = Q30_ONE;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      term = ((term * f) >> 30) / 64'(k);
      if (k % 2 == 1) acc = (acc >= term) ? acc - term : 64'd0;
      else acc = acc + term;
    end
    return acc;
  endfunction

  function automatic forcing_result_t forcing_of_phase(input logic [15:0] x);
    forcing_result_t res;
    int unsigned     count;
    logic [63:0]     d, t, j, psum, den;
    logic [16:0]     psi;
    longint          wsum, a, q;
    count = (active_q > NKERN) ? NKERN : active_q;
    wsum  = 0;
    psum  = '0;
    for (int i = 0; i < count; i++) begin
      if (x >= kernel_bank[i].center) d = 64'(x - kernel_bank[i].center);
      else d = 64'(kernel_bank[i].center - x);
      t   = (64'(kernel_bank[i].width) * (d * d)) >> 32;
      psi = '0;
      if (t <= 64'(thresh_q)) begin
        j = (t * LUT_DEPTH + (64'd1 << (SPAN_SHIFT - 1))) >> SPAN_SHIFT;
        if (j < LUT_DEPTH) psi = exp_lut[j];
      end
      if (psi != 0) begin
        // The arithmetic shift floors the Q16.16 product of slope and phase.
        a    = (longint'($signed(kernel_bank[i].slope)) * longint'(x)) >>> 16;
        a    = a + longint'($signed(kernel_bank[i].offset));
        wsum = wsum + a * longint'(psi);
        psum = psum + 64'(psi);
      end
    end
    den = psum + 64'(guard_q);
    if (den == 0) q = 0;
    else q = wsum / longint'(den);
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    else if (q < -64'sd2147483648) q = -64'sd2147483648;
    res.value = 32'(q);
    res.sum   = (psum > 64'h7F_FFFF) ? 23'h7F_FFFF : psum[22:0];
    return res;
  endfunction

  function automatic kernel_t random_kernel();
    kernel_t k;
    k.center = 16'($urandom);
    // Narrow kernels mostly, so that activations are not all truncated away.
    case ($urandom_range(9))
      0, 1:    k.width = $urandom;
      2, 3:    k.width = $urandom_range(0, 32'h0004_0000);
      default: k.width = $urandom_range(0, 32'h0040_0000);
    endcase
    if ($urandom_range(1)) begin
      k.slope  = $urandom;
      k.offset = $urandom;
    end else begin
      k.slope  = $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
      k.offset = $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
    end
    return k;
  endfunction

  function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [31:0] val);
    stim_row_t r;
    r         = '0;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic stim_row_t wr_row(input logic [5:0] kidx, input logic [15:0] c,
                                      input logic [31:0] w, input logic [31:0] s,
                                      input logic [31:0] o);
    stim_row_t r;
    r             = '0;
    r.kind        = ROW_ITEM;
    r.op          = OP_WRITE;
    r.kidx        = kidx;
    r.kern.center = c;
    r.kern.width  = w;
    r.kern.slope  = s;
    r.kern.offset = o;
    return r;
  endfunction

  function automatic stim_row_t ev_row(input logic [15:0] x, input logic typed,
                                      input logic [31:0] value, input logic [22:0] sum);
    stim_row_t r;
    r            = '0;
    r.kind       = ROW_ITEM;
    r.op         = OP_EVAL;
    r.phase      = x;
    r.typed      = typed;
    r.want.value = value;
    r.want.sum   = sum;
    return r;
  endfunction

  // Offers one item, waits for its transfer and records its effect.
  task automatic send_item(input logic op, input logic [5:0] kidx, input kernel_t kern,
                           input logic [15:0] x, input logic typed,
                           input forcing_result_t typed_res);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    kernel_index_i  <= kidx;
    center_i        <= kern.center;
    width_factor_i  <= kern.width;
    slope_weight_i  <= kern.slope;
    offset_weight_i <= kern.offset;
    phase_i         <= x;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    if (op == OP_WRITE) begin
      kernel_bank[kidx] = kern;
      written[kidx]     = 1'b1;
    end else begin
      pending_results.push_back(typed ? typed_res : forcing_of_phase(x));
    end
  endtask

  // Holds the sender back until every evaluation in flight has delivered.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_ACTIVE_KERNELS: active_q = val[6:0];
      REG_TRUNC_THRESH:   thresh_q = val;
      REG_ZERO_GUARD:     guard_q  = val[15:0];
      default: ;
    endcase
  endtask

  initial begin
    forcing_result_t none_res;
    kernel_t         k;
    logic [31:0]     act_v, thr_v, guard_v;
    logic [63:0]     e1, v, num;
    logic [5:0]      kidx;
    int unsigned     count, len, phase_no;

    none_res        = '0;
    errors          = 0;
    items_sent      = 0;
    calm            = 1'b0;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= '0;
    cfg_wdata_i     <= '0;
    in_valid_i      <= 1'b0;
    opcode_i        <= OP_WRITE;
    kernel_index_i  <= '0;
    center_i        <= '0;
    width_factor_i  <= '0;
    slope_weight_i  <= '0;
    offset_weight_i <= '0;
    phase_i         <= '0;

    // Exponential lookup: fractional part by series, whole units by exp(-1).
    e1 = exp_neg_q30(Q30_ONE);
    for (int j = 0; j < LUT_DEPTH; j++) begin
      num = 64'(16 * j);
      v   = exp_neg_q30(((num % LUT_DEPTH) << 30) / LUT_DEPTH);
      repeat (num / LUT_DEPTH) v = (v * e1) >> 30;
      exp_lut[j] = 17'((v + (64'd1 << 13)) >> 14);
    end

    active_q = ACTIVE_RESET;
    thresh_q = THRESH_RESET;
    guard_q  = GUARD_RESET;
    foreach (kernel_bank[i]) begin
      kernel_bank[i] = '0;
      written[i]     = 1'b0;
    end

    // A single kernel of zero width has an activation of exactly 1.0, so with
    // no guard the result is that kernel's weight, saturated.
    stim_table[0]  = cfg_row(REG_ACTIVE_KERNELS, 32'd1);
    stim_table[1]  = cfg_row(REG_ZERO_GUARD, 32'd0);
    stim_table[2]  = wr_row(6'd0, 16'h8000, 32'h0, 32'h0, 32'h7FFF_FFFF);
    stim_table[3]  = ev_row(16'h1234, 1'b1, 32'h7FFF_FFFF, 23'd65536);
    stim_table[4]  = wr_row(6'd0, 16'hFFFF, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    stim_table[5]  = ev_row(16'hFFFF, 1'b1, 32'h7FFF_FFFF, 23'd65536);
    stim_table[6]  = wr_row(6'd0, 16'h0000, 32'h0, 32'h8000_0000, 32'h8000_0000);
    stim_table[7]  = ev_row(16'hFFFF, 1'b1, 32'h8000_0000, 23'd65536);
    stim_table[8]  = ev_row(16'h0000, 1'b0, '0, '0);
    // Widest kernel: far from the centre every activation is truncated.
    stim_table[9]  = wr_row(6'd0, 16'h0000, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 32'h0005_0000);
    stim_table[10] = ev_row(16'hFFFF, 1'b1, '0, '0);
    stim_table[11] = cfg_row(REG_TRUNC_THRESH, 32'hFFFF_FFFF);
    stim_table[12] = ev_row(16'hFFFF, 1'b1, '0, '0);
    stim_table[13] = ev_row(16'h0000, 1'b1, 32'h0005_0000, 23'd65536);
    stim_table[14] = cfg_row(REG_TRUNC_THRESH, 32'd0);
    stim_table[15] = ev_row(16'h0001, 1'b0, '0, '0);
    stim_table[16] = ev_row(16'h0002, 1'b0, '0, '0);
    // No kernels in use, with the largest guard and then with none at all.
    stim_table[17] = cfg_row(REG_ACTIVE_KERNELS, 32'd0);
    stim_table[18] = cfg_row(REG_ZERO_GUARD, 32'h0000_FFFF);
    stim_table[19] = ev_row(16'h8000, 1'b1, '0, '0);
    stim_table[20] = cfg_row(REG_ZERO_GUARD, 32'd0);
    stim_table[21] = ev_row(16'h8000, 1'b1, '0, '0);
    stim_table[22] = cfg_row(REG_ACTIVE_KERNELS, 32'd4);
    stim_table[23] = cfg_row(REG_TRUNC_THRESH, THRESH_RESET);
    stim_table[24] = cfg_row(REG_ZERO_GUARD, 32'(GUARD_RESET));
    stim_table[25] = wr_row(6'd1, 16'h4000, 32'h0010_0000, 32'h0001_0000, 32'hFFFF_0000);
    stim_table[26] = wr_row(6'd2, 16'hC000, 32'h0008_0000, 32'hFFF0_0000, 32'h0020_0000);
    stim_table[27] = wr_row(6'd3, 16'h8000, 32'h0040_0000, 32'h1234_5678, 32'h0ABC_DEF0);
    stim_table[28] = wr_row(6'd63, 16'hFFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    stim_table[29] = ev_row(16'h8000, 1'b0, '0, '0);
    stim_table[30] = ev_row(16'h2000, 1'b0, '0, '0);
    stim_table[31] = ev_row(16'hC3A5, 1'b0, '0, '0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (stim_table[r]) begin
      if (stim_table[r].kind == ROW_CFG) begin
        settle();
        set_reg(stim_table[r].reg_idx, stim_table[r].reg_val);
      end else begin
        send_item(stim_table[r].op, stim_table[r].kidx, stim_table[r].kern,
                  stim_table[r].phase, stim_table[r].typed, stim_table[r].want);
      end
    end

    // Random phases: fresh settings, then any missing kernels, then traffic.
    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      settle();
      calm = (phase_no == 4);
      case (phase_no)
        0: begin
          act_v   = 32'd64;
          thr_v   = THRESH_RESET;
          guard_v = $urandom_range(0, 16'hFFFF);
        end
        1: begin
          act_v   = 32'd127;
          thr_v   = 32'hFFFF_FFFF;
          guard_v = 32'h0000_FFFF;
        end
        default: begin
          case ($urandom_range(9))
            0, 1, 2, 3, 4: act_v = $urandom_range(1, 6);
            5, 6:          act_v = $urandom_range(7, 24);
            7:             act_v = $urandom_range(1, 3);
            8:             act_v = 32'd0;
            default:       act_v = $urandom_range(65, 127);
          endcase
          case ($urandom_range(9))
            0, 1, 2, 3: thr_v = THRESH_RESET;
            4, 5, 6, 7: thr_v = $urandom_range(0, 32'h0014_0000);
            8:          thr_v = $urandom;
            default:    thr_v = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
          endcase
          case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: guard_v = $urandom_range(0, 16'hFFFF);
            6:                guard_v = 32'd0;
            7:                guard_v = 32'h0000_FFFF;
            default:          guard_v = 32'd1;
          endcase
        end
      endcase
      set_reg(REG_ACTIVE_KERNELS, act_v);
      set_reg(REG_TRUNC_THRESH, thr_v);
      set_reg(REG_ZERO_GUARD, guard_v);

      count = (act_v > NKERN) ? NKERN : act_v;
      for (int i = 0; i < count; i++) begin
        if (!written[i]) send_item(OP_WRITE, 6'(i), random_kernel(), 16'($urandom), 1'b0,
                                   none_res);
      end

      len = (count > 24) ? $urandom_range(6, 12) : $urandom_range(30, 60);
      repeat (len) begin
        k = random_kernel();
        if ($urandom_range(99) < 30) begin
          if (count != 0 && $urandom_range(1)) kidx = 6'($urandom_range(0, count - 1));
          else kidx = 6'($urandom);
          send_item(OP_WRITE, kidx, k, 16'($urandom), 1'b0, none_res);
        end else begin
          send_item(OP_EVAL, 6'($urandom), k, 16'($urandom), 1'b0, none_res);
        end
      end
      phase_no++;
    end

    calm = 1'b0;
    settle();
    repeat (SLOWEST_EVAL) @(posedge clk_i);
    if (errors == 0) begin
      $display("truncated_rbf_forcing_term: match");
    end else begin
      $display("truncated_rbf_forcing_term: mismatch");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 15);
  end

  // Each result transfer is checked against the oldest outstanding evaluation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %h / %h", $time,
                   forcing_value_o, activation_sum_o);
      end else begin
        oldest = pending_results.pop_front();
        if (forcing_value_o !== oldest.value) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: forcing_value expected %h, actual %h", $time, oldest.value,
                     forcing_value_o);
        end
        if (activation_sum_o !== oldest.sum) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: activation_sum expected %h, actual %h", $time, oldest.sum,
                     activation_sum_o);
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("truncated_rbf_forcing_term: mismatch");
    $finish;
  end

endmodule

### filelist.f
src/trbf_pkg.sv
src/trbf_kernel_mem.sv
src/trbf_exp_rom.sv
src/trbf_divider.sv
src/truncated_rbf_forcing_term.sv
test/truncated_rbf_forcing_term_tb.sv
